FILE: hw/rtl/indexed_insert_remove_list_defines.svh
// Assertion macros for the indexed insert/remove list.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef INDEXED_INSERT_REMOVE_LIST_DEFINES_SVH
`define INDEXED_INSERT_REMOVE_LIST_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check that cons holds in the same cycle as ante.
`define IIRL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check that cons holds in the cycle after ante.
`define IIRL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define IIRL_ASSERT_SAME(lbl, ante, cons)
`define IIRL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hw/rtl/iirl_pkg.sv
package iirl_pkg;

  // List size and field widths
  localparam int unsigned Capacity = 16;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned CntW     = 5;
  localparam int unsigned DataW    = 32;
  localparam int unsigned StatW    = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_APPEND  = 2'd0,
    CMD_INSERT  = 2'd1,
    CMD_REMOVE  = 2'd2,
    CMD_SET_LEN = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } stat_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the request operands
    logic commit;  // check and apply the captured request
  } ctrl_t;

endpackage

FILE: hw/rtl/iirl_ctrl.sv
module iirl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  output logic            done_o,
  output iirl_pkg::ctrl_t ctrl_o
);
  import iirl_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic done_q, done_d;
  logic accept;

  assign accept = start_i && (state_q == S_IDLE);

  // Sequence each request through the execute state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Pulse done in the cycle after the commit
  assign done_d = (state_q == S_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o        = (state_q == S_EXEC);
  assign done_o        = done_q;
  assign ctrl_o.load   = accept;
  assign ctrl_o.commit = (state_q == S_EXEC);

endmodule

FILE: hw/rtl/iirl_dp.sv
module iirl_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  iirl_pkg::ctrl_t                   ctrl_i,
  input  logic [iirl_pkg::CmdW-1:0]         command_i,
  input  logic [iirl_pkg::CntW-1:0]         position_i,
  input  logic signed [iirl_pkg::DataW-1:0] value_i,
  output logic [iirl_pkg::StatW-1:0]        status_o,
  output logic [iirl_pkg::CntW-1:0]         count_o
);
  import iirl_pkg::*;

  localparam logic [CntW-1:0] CapCnt = CntW'(Capacity);

  // Captured request operands
  cmd_e                    op_cmd_q;
  logic [CntW-1:0]         op_pos_q;
  logic signed [DataW-1:0] op_val_q;

  logic signed [DataW-1:0] entry_q [Capacity];
  logic [CntW-1:0]         count_q, count_d;
  stat_e                   status_q, status_d;
  logic                    app_en, ins_en, rem_en;

  // Hold the operands of an accepted request
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_cmd_q <= cmd_e'(command_i);
      op_pos_q <= position_i;
      op_val_q <= value_i;
    end
  end

  // Check the request against the count and pick the new count
  always_comb begin
    status_d = ST_OK;
    count_d  = count_q;
    app_en   = 1'b0;
    ins_en   = 1'b0;
    rem_en   = 1'b0;
    case (op_cmd_q)
      CMD_APPEND: begin
        if (count_q >= CapCnt) begin
          status_d = ST_FULL;
        end else begin
          app_en  = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      CMD_INSERT: begin
        if (op_pos_q > count_q) begin
          status_d = ST_BAD_INDEX;
        end else if (count_q >= CapCnt) begin
          status_d = ST_FULL;
        end else begin
          ins_en  = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (op_pos_q >= count_q) begin
          status_d = ST_BAD_INDEX;
        end else begin
          rem_en  = 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      default: begin
        if (op_pos_q > CapCnt) begin
          status_d = ST_FULL;
        end else begin
          count_d = op_pos_q;
        end
      end
    endcase
  end

  // Shift the entries in parallel, one slot each way
  for (genvar i = 0; i < Capacity; i++) begin : g_entry
    localparam logic [CntW-1:0] Idx     = CntW'(i);
    localparam logic [CntW-1:0] IdxNext = CntW'(i + 1);
    logic signed [DataW-1:0] below, above;

    if (i == 0) begin : g_first
      assign below = entry_q[i];
    end else begin : g_inner_lo
      assign below = entry_q[i-1];
    end
    if (i == Capacity - 1) begin : g_last
      assign above = entry_q[i];
    end else begin : g_inner_hi
      assign above = entry_q[i+1];
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.commit) begin
        if (app_en && (Idx == count_q)) begin
          entry_q[i] <= op_val_q;
        end else if (ins_en && (Idx == op_pos_q)) begin
          entry_q[i] <= op_val_q;
        end else if (ins_en && (Idx > op_pos_q) && (Idx <= count_q)) begin
          entry_q[i] <= below;
        end else if (rem_en && (Idx >= op_pos_q) && (IdxNext < count_q)) begin
          entry_q[i] <= above;
        end
      end
    end
  end

  // Advance the count and record the status on commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.commit) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      status_q <= status_d;
    end
  end

  assign status_o = status_q;
  assign count_o  = count_q;

endmodule

FILE: hw/rtl/indexed_insert_remove_list.sv
// Channel   Handshake                Fields
// request   start (in), busy (out)   command_i, position_i, value_i
// result    done_o (out)             status_o, count_o
//
// A request is taken on a clock edge where start is high and busy is low.
// Each request is first captured, then checked and used to shift the
// entry register file; its result shows on done_o in the cycle after that.
// A new request can be taken in the same cycle the previous result shows.
// Reset clears the count to zero; the entry contents are not reset.
// The result is shown for one cycle only; the receiver cannot stall it.
`include "indexed_insert_remove_list_defines.svh"

module indexed_insert_remove_list (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [iirl_pkg::CmdW-1:0]         command_i,
  input  logic [iirl_pkg::CntW-1:0]         position_i,
  input  logic signed [iirl_pkg::DataW-1:0] value_i,
  output logic                              done_o,
  output logic [iirl_pkg::StatW-1:0]        status_o,
  output logic [iirl_pkg::CntW-1:0]         count_o
);
  import iirl_pkg::*;

  ctrl_t ctrl;

  iirl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .ctrl_o  (ctrl)
  );

  iirl_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .command_i  (command_i),
    .position_i (position_i),
    .value_i    (value_i),
    .status_o   (status_o),
    .count_o    (count_o)
  );

  // Each taken request is followed by a result strobe
  `IIRL_ASSERT_SAME(a_done_latency, start && !busy, ##2 done_o)
  // Busy is always low in the cycle after it is high
  `IIRL_ASSERT_NEXT(a_busy_single, busy, !busy)
  // Count never exceeds the capacity
  `IIRL_ASSERT_SAME(a_count_cap, 1'b1, count_o <= CntW'(Capacity))
  // A refused request leaves the count unchanged
  `IIRL_ASSERT_SAME(a_refused_keep, done_o && (status_o != ST_OK), count_o == $past(count_o))

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import iirl_pkg::*;

  localparam int unsigned RandRequests = 1450;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned MaxGap       = 15;

  typedef struct packed {
    stat_e           status;
    logic [CntW-1:0] count;
  } list_result_t;

  // Track the list contents and count, and queue the status each request should return
  class list_scoreboard;
    logic [DataW-1:0] entries_q [Capacity];
    logic [CntW-1:0]  count_q;
    list_result_t     expected_q [$];
    int unsigned      errors;

    function new();
      count_q = '0;
      errors  = 0;
    endfunction

    task report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // Apply one accepted request to the shadow list
    function void note_request(input cmd_e cmd, input logic [CntW-1:0] pos,
                               input logic [DataW-1:0] val);
      list_result_t res;
      int unsigned  n;
      int unsigned  i;
      n          = count_q;
      res.status = ST_OK;
      case (cmd)
        CMD_APPEND: begin
          if (n >= Capacity) begin
            res.status = ST_FULL;
          end else begin
            entries_q[n] = val;
            count_q      = CntW'(n + 1);
          end
        end
        CMD_INSERT: begin
          // Range check comes before the full check
          if (pos > n) begin
            res.status = ST_BAD_INDEX;
          end else if (n >= Capacity) begin
            res.status = ST_FULL;
          end else begin
            for (i = n; i > pos; i--) entries_q[i] = entries_q[i-1];
            entries_q[pos] = val;
            count_q        = CntW'(n + 1);
          end
        end
        CMD_REMOVE: begin
          if (pos >= n) begin
            res.status = ST_BAD_INDEX;
          end else begin
            for (i = pos; i + 1 < n; i++) entries_q[i] = entries_q[i+1];
            count_q = CntW'(n - 1);
          end
        end
        default: begin
          if (pos > Capacity) begin
            res.status = ST_FULL;
          end else begin
            count_q = pos;
          end
        end
      endcase
      res.count = count_q;
      expected_q.push_back(res);
    endfunction

    // Compare one result against the oldest expectation
    task check_result(input logic [StatW-1:0] status, input logic [CntW-1:0] count);
      list_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d count=%0d", status, count));
        return;
      end
      want = expected_q.pop_front();
      if (status !== want.status) begin
        report_mismatch($sformatf("status got %0d want %0d", status, want.status));
      end
      if (count !== want.count) begin
        report_mismatch($sformatf("count got %0d want %0d", count, want.count));
      end
    endtask
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [CmdW-1:0]          command_i;
  logic [CntW-1:0]          position_i;
  logic signed [DataW-1:0]  value_i;
  logic                     done_o;
  logic [StatW-1:0]         status_o;
  logic [CntW-1:0]          count_o;

  list_scoreboard sb;
  int unsigned    cycle_cnt;

  indexed_insert_remove_list u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .command_i  (command_i),
    .position_i (position_i),
    .value_i    (value_i),
    .done_o     (done_o),
    .status_o   (status_o),
    .count_o    (count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Check every strobed result
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      sb.check_result(status_o, count_o);
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Idle for gap cycles, then hold the request until it is taken
  task automatic send_request(input cmd_e cmd, input logic [CntW-1:0] pos,
                              input logic [DataW-1:0] val, input int unsigned gap);
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start      <= 1'b1;
    command_i  <= cmd;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_request(cmd, pos, val);
  endtask

  // Draw mostly in-range requests, with some out-of-range positions mixed in
  task automatic pick_request(output cmd_e cmd, output logic [CntW-1:0] pos,
                              output logic [DataW-1:0] val);
    int unsigned sel;
    int unsigned n;
    bit          noise;
    sel   = $urandom_range(0, 99);
    noise = ($urandom_range(0, 9) == 0);
    n     = sb.count_q;
    val   = $urandom();
    pos   = CntW'($urandom_range(0, 31));
    if (sel < 30) begin
      cmd = CMD_APPEND;
    end else if (sel < 60) begin
      cmd = CMD_INSERT;
      if (!noise) pos = CntW'($urandom_range(0, n));
    end else if (sel < 90) begin
      cmd = CMD_REMOVE;
      if (!noise) pos = (n == 0) ? '0 : CntW'($urandom_range(0, n - 1));
    end else begin
      cmd = CMD_SET_LEN;
      if (!noise) pos = CntW'($urandom_range(0, Capacity));
    end
  endtask

  initial begin
    cmd_e             cmd;
    logic [CntW-1:0]  pos;
    logic [DataW-1:0] val;
    int unsigned      sent;
    int unsigned      run_len;
    int unsigned      k;
    bit               burst;

    sb         = new();
    cycle_cnt  = 0;
    rst_ni     = 1'b0;
    start      = 1'b0;
    command_i  = CMD_APPEND;
    position_i = '0;
    value_i    = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Fill the list so that every entry has been written
    for (k = 0; k < Capacity; k++) begin
      case (k)
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        2:       val = '0;
        3:       val = '1;
        default: val = $urandom();
      endcase
      send_request(CMD_APPEND, (k == 1) ? 5'h1F : CntW'(k), val, $urandom_range(0, MaxGap));
    end
    // Full list, range checks, and set length edges
    send_request(CMD_APPEND,  5'd0,  $urandom(), 0);
    send_request(CMD_INSERT,  5'd16, $urandom(), 0);
    send_request(CMD_INSERT,  5'd17, $urandom(), 1);
    send_request(CMD_SET_LEN, 5'd17, $urandom(), 0);
    send_request(CMD_SET_LEN, 5'd31, $urandom(), 2);
    send_request(CMD_REMOVE,  5'd16, $urandom(), 0);
    send_request(CMD_REMOVE,  5'd15, $urandom(), 0);
    send_request(CMD_REMOVE,  5'd0,  $urandom(), 3);
    send_request(CMD_INSERT,  5'd14, 32'h7FFF_FFFF, 0);
    send_request(CMD_INSERT,  5'd0,  32'h8000_0000, 0);
    send_request(CMD_SET_LEN, 5'd16, $urandom(), 0);
    send_request(CMD_SET_LEN, 5'd0,  $urandom(), 0);
    send_request(CMD_REMOVE,  5'd0,  $urandom(), 0);
    send_request(CMD_INSERT,  5'd1,  $urandom(), 0);
    send_request(CMD_INSERT,  5'd0,  '1, 5);
    send_request(CMD_SET_LEN, 5'd16, $urandom(), 0);

    // Random requests in runs, some back to back and some with idle gaps
    sent = 0;
    while (sent < RandRequests) begin
      burst   = ($urandom_range(0, 3) == 0);
      run_len = $urandom_range(10, 60);
      if (run_len > RandRequests - sent) run_len = RandRequests - sent;
      repeat (run_len) begin
        pick_request(cmd, pos, val);
        send_request(cmd, pos, val, burst ? 0 : $urandom_range(0, MaxGap));
        sent++;
      end
    end
    @(negedge clk_i);
    start <= 1'b0;

    // Drain outstanding results, then allow for any stray strobes
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
